@@ rtl/fpp_pkg.sv @@
// Package for the double-to-PCM sample packer: format codes and the
// pipeline stage structures. No dependencies.
package fpp_pkg;

	typedef enum logic [2:0] {
		FMT_PCM16 = 3'd0,
		FMT_PCM24 = 3'd1,
		FMT_PCM32 = 3'd2,
		FMT_F32   = 3'd3,
		FMT_F64   = 3'd4
	} fmt_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  fmt;
		logic        pad;
		logic [63:0] bits;
	} s1_t;

	typedef struct packed {
		logic        valid;
		logic [3:0]  nbytes;
		logic [63:0] word;
	} word_t;

endpackage

@@ rtl/fpp_pcm_conv.sv @@
// PCM conversion stages: exponent decode and saturation, then the
// magnitude shift and two's complement. Depends on fpp_pkg.
module fpp_pcm_conv (
	input  logic clk,
	input  fpp_pkg::s1_t in_s1,
	output logic [31:0] pcm_s3
);
	import fpp_pkg::*;

	logic [10:0] exp_w;
	logic [4:0]  nm1_w;
	logic        zero_s2, sat_s2, neg_s2;
	logic [5:0]  sh_s2;
	logic [4:0]  nm1_s2;
	logic [52:0] man_s2;
	logic [31:0] mag_w, sat_w, val_w;

	assign exp_w = in_s1.bits[62:52];
	always_comb begin
		case (in_s1.fmt)
			FMT_PCM16: nm1_w = 5'd15;
			FMT_PCM24: nm1_w = 5'd23;
			default:   nm1_w = 5'd31;
		endcase
	end

	always_ff @(posedge clk) begin
		neg_s2  <= in_s1.bits[63];
		nm1_s2  <= nm1_w;
		man_s2  <= {1'b1, in_s1.bits[51:0]};
		zero_s2 <= in_s1.pad || (exp_w < 11'd1023 - 11'(nm1_w))
			|| (exp_w == 11'h7FF && in_s1.bits[51:0] != 52'd0);
		sat_s2  <= (exp_w >= 11'd1023);
		sh_s2   <= 6'(11'd1075 - 11'(nm1_w) - exp_w);
	end

	assign mag_w = 32'(man_s2 >> sh_s2);
	assign sat_w = neg_s2 ? (32'd1 << nm1_s2) : ((32'd1 << nm1_s2) - 32'd1);
	assign val_w = sat_s2 ? sat_w : mag_w;

	always_ff @(posedge clk) begin
		if (zero_s2)
			pcm_s3 <= 32'd0;
		else
			pcm_s3 <= neg_s2 ? (~val_w + 32'd1) : val_w;
	end
endmodule

@@ rtl/fpp_f32_conv.sv @@
// Float32 rounding stages: exponent rebias, subnormal shift and
// round-to-nearest-even. Depends on fpp_pkg.
module fpp_f32_conv (
	input  logic clk,
	input  fpp_pkg::s1_t in_s1,
	output logic [31:0] f32_s3
);
	import fpp_pkg::*;

	logic        sgn_s2, nan_s2, inf_s2, tiny_s2;
	logic [22:0] nanm_s2;
	logic [7:0]  e_s2;
	logic [6:0]  sh_s2;
	logic [52:0] man_s2;
	logic [62:0] mag;
	logic [12:0] e32;
	logic [54:0] ext;
	logic [54:0] shifted;
	logic        sticky;
	logic [23:0] sig;
	logic        g, r;
	logic [31:0] base;

	assign mag = in_s1.bits[62:0];
	assign e32 = 13'(in_s1.bits[62:52]) - 13'd896;

	always_ff @(posedge clk) begin
		sgn_s2  <= in_s1.bits[63];
		nanm_s2 <= in_s1.bits[51:29];
		nan_s2  <= mag > 63'h7FF0000000000000;
		inf_s2  <= mag >= 63'h47EFFFFFF0000000;
		tiny_s2 <= in_s1.bits[62:52] < 11'd846;
		man_s2  <= {in_s1.bits[62:52] != 11'd0, in_s1.bits[51:0]};
		e_s2    <= (e32[12] || e32 == 13'd0) ? 8'd0 : e32[7:0];
		sh_s2   <= (e32[12] || e32 == 13'd0) ? 7'(13'd1 - e32) : 7'd0;
	end

	// Shift the 53-bit significand right for subnormals, keeping sticky.
	always_comb begin
		ext     = {man_s2, 2'b00};
		shifted = (sh_s2 > 7'd54) ? 55'd0 : (ext >> sh_s2);
		sticky  = (sh_s2 > 7'd54) ? (man_s2 != 53'd0)
			: ((ext & ~(55'h7FFFFFFFFFFFFF << sh_s2)) != 55'd0);
		sig     = shifted[54:31];
		g       = shifted[30];
		r       = (shifted[29:0] != 30'd0) || sticky;
		base    = {1'b0, e_s2, sig[22:0]};
	end

	always_ff @(posedge clk) begin
		if (nan_s2)
			f32_s3 <= {sgn_s2, 9'h1FF, 22'd0} | {9'd0, nanm_s2};
		else if (inf_s2)
			f32_s3 <= {sgn_s2, 31'h7F800000};
		else if (tiny_s2)
			f32_s3 <= {sgn_s2, 31'd0};
		else
			f32_s3 <= {sgn_s2, 31'(base + 32'(g && (r || sig[0])))};
	end
endmodule

@@ rtl/fpp_serializer.sv @@
// Byte serialiser with a word queue of two entries: emits one byte a
// cycle, least significant first. Depends on fpp_pkg.
module fpp_serializer (
	input  logic clk,
	input  logic arst_n,
	input  fpp_pkg::word_t in_w,
	output logic full,
	output logic [7:0] out_byte,
	output logic last,
	output logic strobe
);
	import fpp_pkg::*;

	word_t      q0_q, q1_q;
	logic [2:0] k_q;
	logic       done;

	assign done     = q0_q.valid && (4'(k_q) + 4'd1 == q0_q.nbytes);
	assign strobe   = q0_q.valid;
	assign out_byte = 8'(q0_q.word >> {k_q, 3'b000});
	assign last     = done;
	assign full     = q1_q.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q0_q.valid <= 1'b0;
			q1_q.valid <= 1'b0;
			k_q <= 3'd0;
		end else begin
			if (done || !q0_q.valid) begin
				k_q <= 3'd0;
				if (q1_q.valid) begin
					q0_q <= q1_q;
					q1_q <= in_w;
				end else begin
					q0_q <= in_w;
					q1_q.valid <= 1'b0;
				end
			end else begin
				k_q <= k_q + 3'd1;
				if (in_w.valid)
					q1_q <= in_w;
			end
		end
	end
endmodule

@@ rtl/float_to_pcm_sample_packer_top.sv @@
// Top level of the double-to-PCM sample packer. Depends on fpp_pkg,
// fpp_pcm_conv, fpp_f32_conv and fpp_serializer.
//
// A request is taken on a rising edge with start high and busy low. It
// passes three register stages of conversion (decode, shift or round,
// select) and then a two-entry word queue feeding the byte serialiser.
// Bytes leave one a cycle with strobe high, least significant first, and
// last marks the final byte of a sample: 2, 3, 4 or 8 bytes by format.
// The first byte reaches the outputs after stages s1, s2 and s3 and the
// head of the word queue. Busy is high while two or more requests are
// held between the input and the output, so two requests may follow each
// other with no gap. The byte-wide output bounds the rate: the 4- and
// 8-byte formats keep it busy from sample to sample, while the pipeline
// depth leaves gaps between 16-bit and 24-bit PCM samples. The receiver
// cannot stall. Format codes five to seven drop the request with no bytes.
// The format register is to be written over cfg_valid/cfg_ready only while
// idle; the block itself does not enforce this.
// Reset clears the format to 16-bit PCM and empties the pipeline.
module float_to_pcm_sample_packer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] sample_bits,
	input  logic        pad,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic        strobe
);
	import fpp_pkg::*;

	logic [2:0]  fmt_q;
	s1_t         s1;
	logic        v_s1, v_s2, v_s3;
	logic        pad_s1, pad_s2, pad_s3;
	logic [2:0]  fmt_s1, fmt_s2, fmt_s3;
	logic [63:0] bits_s1, bits_s2, bits_s3;
	logic [31:0] pcm_s3, f32_s3;
	logic [2:0]  held;
	word_t       w;
	logic        full;

	assign cfg_ready = 1'b1;
	assign s1 = {v_s1, fmt_s1, pad_s1, bits_s1};
	assign held = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(strobe) + 3'(full);
	assign busy = (held >= 3'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_PCM16;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (cfg_valid)
				fmt_q <= cfg_data;
			v_s1 <= start && !busy && fmt_q <= FMT_F64;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		fmt_s1 <= fmt_q;
		pad_s1 <= pad;
		bits_s1 <= sample_bits;
		fmt_s2 <= fmt_s1;
		pad_s2 <= pad_s1;
		bits_s2 <= bits_s1;
		fmt_s3 <= fmt_s2;
		pad_s3 <= pad_s2;
		bits_s3 <= bits_s2;
	end

	fpp_pcm_conv u_pcm (.clk, .in_s1(s1), .pcm_s3);
	fpp_f32_conv u_f32 (.clk, .in_s1(s1), .f32_s3);

	always_comb begin
		w.valid = v_s3;
		unique case (fmt_s3)
			FMT_PCM16: begin w.nbytes = 4'd2; w.word = {48'd0, pcm_s3[15:0]}; end
			FMT_PCM24: begin w.nbytes = 4'd3; w.word = {40'd0, pcm_s3[23:0]}; end
			FMT_PCM32: begin w.nbytes = 4'd4; w.word = {32'd0, pcm_s3}; end
			FMT_F32:   begin w.nbytes = 4'd4; w.word = {32'd0, f32_s3}; end
			default:   begin w.nbytes = 4'd8; w.word = bits_s3; end
		endcase
		if (pad_s3)
			w.word = 64'd0;
	end

	fpp_serializer u_ser (.clk, .arst_n, .in_w(w), .full, .out_byte, .last, .strobe);

	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe) else $error("last without strobe");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s3 && full)) else $error("word arrives at a full queue");
	a_drop_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && fmt_q > FMT_F64) |=> !v_s1)
		else $error("request with an unused format entered the pipeline");
endmodule

@@ tb/tb.sv @@
// Testbench for the double-to-PCM sample packer: drives samples through the
// command port, predicts every output byte and checks the byte stream.
// Depends on fpp_pkg and float_to_pcm_sample_packer_top.
`timescale 1ns / 1ps

module tb;
	import fpp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic [7:0] byte_val;
		logic       last_val;
	} byte_exp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [63:0] sample_bits = '0;
	logic        pad = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_data = '0;
	logic [7:0]  out_byte;
	logic        last;
	logic        strobe;

	byte_exp_t   pending_bytes[$];
	logic [2:0]  cur_format;
	int          mismatches = 0;
	int          cycles = 0;
	int          samples_sent = 0;
	int          bytes_seen = 0;

	float_to_pcm_sample_packer_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample_bits(sample_bits), .pad(pad),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.out_byte(out_byte), .last(last), .strobe(strobe)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [63:0] pcm_code(logic [63:0] bits, int nbits);
		real v, s, neg_lim, pos_lim;
		longint mag;
		begin
			v = $bitstoreal(bits);
			neg_lim = 2.0 ** (nbits - 1);
			pos_lim = neg_lim - 1.0;
			if (v < 0.0) begin
				s = -(v * neg_lim);
				if (s >= neg_lim)
					mag = longint'(1) << (nbits - 1);
				else
					mag = longint'($rtoi(s));
				return ~mag + 64'd1;
			end
			if (v == 0.0)
				return 64'd0;
			s = v * neg_lim;
			if (!(s > 0.0))
				return 64'd0;
			if (s > pos_lim)
				s = pos_lim;
			return 64'($rtoi(s));
		end
	endfunction

	function automatic logic [31:0] f32_bits(logic [63:0] bits);
		logic [63:0] mag, sig, keep, rem, half;
		logic [31:0] sign;
		int e, shift;
		logic [7:0] exp32;
		begin
			mag = {1'b0, bits[62:0]};
			sign = {bits[63], 31'd0};
			if (mag > 64'h7FF0000000000000)
				return sign | 32'h7FC00000 | 32'(mag[51:29]);
			if (mag >= 64'h47EFFFFFF0000000)
				return sign | 32'h7F800000;
			if (bits[62:52] == 11'd0)
				return sign;
			e = int'(bits[62:52]) - 1023;
			sig = {11'd0, 1'b1, bits[51:0]};
			shift = (e >= -126) ? 29 : 29 + (-126 - e);
			if (shift > 62)
				return sign;
			keep = sig >> shift;
			rem = sig & ((64'd1 << shift) - 64'd1);
			half = 64'd1 << (shift - 1);
			if (rem > half || (rem == half && keep[0]))
				keep = keep + 64'd1;
			if (e < -126)
				return sign | 32'(keep);
			exp32 = 8'(e + 127);
			if (keep[24]) begin
				keep = keep >> 1;
				exp32 = exp32 + 8'd1;
			end
			return sign | {1'b0, exp32, keep[22:0]};
		end
	endfunction

	task automatic encode_sample(logic [63:0] bits, logic pad_in);
		logic [63:0] word;
		int n;
		byte_exp_t b;
		begin
			word = '0;
			case (cur_format)
				FMT_PCM16: begin n = 2; if (!pad_in) word = pcm_code(bits, 16); end
				FMT_PCM24: begin n = 3; if (!pad_in) word = pcm_code(bits, 24); end
				FMT_PCM32: begin n = 4; if (!pad_in) word = pcm_code(bits, 32); end
				FMT_F32: begin n = 4; if (!pad_in) word = 64'(f32_bits(bits)); end
				FMT_F64: begin n = 8; if (!pad_in) word = bits; end
				default: n = 0;
			endcase
			for (int k = 0; k < n; k++) begin
				b.byte_val = word[8*k +: 8];
				b.last_val = (k == n - 1);
				pending_bytes.push_back(b);
			end
		end
	endtask

	always @(negedge clk) begin
		byte_exp_t b;
		if (arst_n && strobe) begin
			bytes_seen++;
			if (pending_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected byte %02h last %b", out_byte, last);
			end else begin
				b = pending_bytes.pop_front();
				if (b.byte_val !== out_byte || b.last_val !== last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %02h/%b got %02h/%b",
							b.byte_val, b.last_val, out_byte, last);
				end
			end
		end
	end

	task automatic send_sample(logic [63:0] bits, logic pad_in);
		logic taken;
		begin
			start <= 1'b1;
			sample_bits <= bits;
			pad <= pad_in;
			do begin
				@(negedge clk);
				taken = !busy;
				@(posedge clk);
			end while (!taken);
			encode_sample(bits, pad_in);
			samples_sent++;
		end
	endtask

	task automatic idle_cycles(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		idle_cycles(1);
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_format(logic [2:0] f);
		logic taken;
		begin
			drain();
			cfg_valid <= 1'b1;
			cfg_data <= f;
			do begin
				@(negedge clk);
				taken = cfg_ready;
				@(posedge clk);
			end while (!taken);
			cfg_valid <= 1'b0;
			cur_format = f;
		end
	endtask

	function automatic logic [63:0] random_sample();
		logic [63:0] r;
		int kind;
		begin
			r = {$urandom, $urandom};
			kind = $urandom_range(0, 9);
			if (kind < 6)
				r[62:52] = 11'(1023 - $urandom_range(0, 30) + $urandom_range(0, 2));
			else if (kind == 6)
				r[62:52] = 11'($urandom_range(0, 1) ? 2047 : $urandom_range(0, 2));
			else if (kind == 7)
				r[62:52] = 11'($urandom_range(1150, 1152));
			else if (kind == 8)
				r[62:52] = 11'($urandom_range(870, 900));
			if ($urandom_range(0, 7) == 0)
				r[28:0] = $urandom_range(0, 1) ? 29'h10000000 : 29'h0;
			return r;
		end
	endfunction

	task automatic test_pcm_directed();
		write_format(FMT_PCM16);
		send_sample(64'h3FF0000000000000, 1'b0);
		send_sample(64'hBFF0000000000000, 1'b0);
		send_sample(64'h8000000000000000, 1'b0);
		send_sample(64'h7FF8000000000001, 1'b0);
		send_sample(64'h7FF0000000000000, 1'b0);
		send_sample(64'hFFF0000000000000, 1'b1);
		write_format(FMT_PCM24);
		send_sample(64'hFFF0000000000000, 1'b0);
		send_sample(64'h3FEFFFFFFFFFFFFF, 1'b0);
		write_format(FMT_PCM32);
		send_sample(64'hBFEFFFFFFFFFFFFF, 1'b0);
		send_sample(64'hC000000000000000, 1'b0);
		send_sample(64'h0000000000000001, 1'b0);
		send_sample(64'hFFFFFFFFFFFFFFFF, 1'b0);
	endtask

	task automatic test_float_directed();
		write_format(FMT_F32);
		send_sample(64'h47EFFFFFF0000000, 1'b0);
		send_sample(64'hC7EFFFFFEFFFFFFF, 1'b0);
		send_sample(64'hFFF4000000000000, 1'b0);
		send_sample(64'h3FF0000010000000, 1'b0);
		send_sample(64'h3FF0000030000000, 1'b0);
		send_sample(64'h36A0000000000000, 1'b0);
		send_sample(64'h380FFFFFF0000000, 1'b0);
		send_sample(64'h3FF0000000000000, 1'b1);
		write_format(FMT_F64);
		send_sample(64'hFFFFFFFFFFFFFFFF, 1'b0);
		send_sample(64'h0123456789ABCDEF, 1'b1);
	endtask

	task automatic test_unused_formats();
		for (int f = 5; f <= 7; f++) begin
			write_format(3'(f));
			send_sample(64'h3FF0000000000000, 1'b0);
		end
	endtask

	task automatic test_random_stream();
		int burst;
		for (int phase = 0; phase < 8; phase++) begin
			write_format(3'($urandom_range(0, 9) < 8 ? $urandom_range(0, 4)
				: $urandom_range(5, 7)));
			for (int i = 0; i < 15; i += burst) begin
				burst = $urandom_range(1, 6);
				for (int j = 0; j < burst; j++)
					send_sample(random_sample(), $urandom_range(0, 9) == 0);
				if ($urandom_range(0, 3) != 0)
					idle_cycles($urandom_range(1, 12));
			end
		end
	endtask

	initial begin
		cur_format = FMT_PCM16;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pcm_directed();
		test_float_directed();
		test_unused_formats();
		test_random_stream();
		write_format(FMT_PCM16);
		drain();
		$display("Sent %0d samples over all five formats and the unused codes.", samples_sent);
		$display("Checked %0d output bytes, %0d mismatches.", bytes_seen, mismatches);
		if (mismatches == 0 && pending_bytes.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
